/* sv/hlf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlf_pkg: shared types and constants for the line-strength factor pipeline
// Field widths, fixed-point format, branch and Delta-Lambda codes, and the
// item that moves along the row of divider cells.
// ----------------------------------------------------------------------------
package hlf_pkg;

    localparam int J_TWICE_BITS  = 8;
    localparam int FRACTION_BITS = 16;   // must not exceed FACTOR_BITS - 1
    localparam int FACTOR_BITS   = 19;

    // one cell per quotient bit below the saturation point
    localparam int QUO_BITS  = FACTOR_BITS - 1;
    localparam int DEN_SHIFT = QUO_BITS - FRACTION_BITS;

    // signed linear terms: up to 2^J_TWICE_BITS - 1 + 18, down to -16
    localparam int TERM_W = J_TWICE_BITS + 3;
    localparam int NUM_W  = 2 * TERM_W;
    // unsigned factors of the denominator: t, t + 1, t + 2
    localparam int MF_W   = J_TWICE_BITS + 1;
    localparam int MDEN_W = 2 * MF_W;
    // denominator with its powers of two and the scaling shift
    localparam int DIV_W  = MDEN_W + 2 + DEN_SHIFT;
    localparam int CMP_W  = (NUM_W > DIV_W) ? NUM_W : DIV_W;

    localparam logic signed [FACTOR_BITS-1:0] FACTOR_MAX =
        {1'b0, {(FACTOR_BITS-1){1'b1}}};
    localparam logic signed [FACTOR_BITS-1:0] FACTOR_MIN =
        {1'b1, {(FACTOR_BITS-1){1'b0}}};
    localparam logic signed [FACTOR_BITS-1:0] FACTOR_ONE =
        (FRACTION_BITS >= FACTOR_BITS - 1) ? FACTOR_MAX
                                           : (FACTOR_BITS'(1) << FRACTION_BITS);

    typedef enum logic [1:0] {
        MODE_P    = 2'd0,
        MODE_Q    = 2'd1,
        MODE_R    = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DL_ZERO  = 2'b00,
        DL_PLUS  = 2'b01,
        DL_BAD   = 2'b10,
        DL_MINUS = 2'b11
    } t_dlam;

    localparam logic [1:0] REG_FORCE_UNITY = 2'd0;

    typedef struct packed {
        logic                neg;
        logic                sat;
        logic [DIV_W-1:0]    rem;
        logic [DIV_W-1:0]    den;
        logic [QUO_BITS-1:0] quo;
    } t_cell_data;

endpackage

/* sv/hlf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlf_front: formula selection and products
// Picks the two linear terms and the denominator factors for the branch,
// multiplies them, then forms the magnitude, the scaled divisor and the
// saturation flag that seed the first divider cell.
// ----------------------------------------------------------------------------
module hlf_front import hlf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [1:0]              i_mode,
    input  logic [J_TWICE_BITS-1:0] i_j_twice,
    input  logic [2:0]              i_lambda_value,
    input  logic signed [1:0]       i_delta_lambda,
    output logic                    o_valid,
    output t_cell_data              o_data
);

    localparam logic signed [TERM_W-1:0] K2 = TERM_W'(2);
    localparam logic signed [TERM_W-1:0] K4 = TERM_W'(4);

    logic signed [TERM_W-1:0] t_s;
    logic signed [TERM_W-1:0] l2_s;
    logic signed [TERM_W-1:0] term_a;
    logic signed [TERM_W-1:0] term_b;
    logic [MF_W-1:0]          t_0;
    logic [MF_W-1:0]          t_1;
    logic [MF_W-1:0]          t_2;
    logic [MF_W-1:0]          m_1;
    logic [MF_W-1:0]          m_2;
    logic [1:0]               dsh;
    logic                     ok;
    t_mode                    mode;
    t_dlam                    dlam;

    logic                     r_a_valid;
    logic                     r_ok;
    logic signed [NUM_W-1:0]  r_prod;
    logic [MDEN_W-1:0]        r_mden;
    logic [1:0]               r_dsh;
    logic signed [NUM_W-1:0]  n_prod;
    logic [MDEN_W-1:0]        n_mden;

    logic                     r_b_valid;
    t_cell_data               r_data;
    t_cell_data               n_data;
    logic [NUM_W-1:0]         mag;
    logic [DIV_W-1:0]         div;
    logic                     neg;

    assign mode = t_mode'(i_mode);
    assign dlam = t_dlam'(i_delta_lambda);
    assign t_s  = signed'(TERM_W'(i_j_twice));
    assign l2_s = signed'(TERM_W'({i_lambda_value, 1'b0}));
    assign t_0  = MF_W'(i_j_twice);
    assign t_1  = MF_W'(i_j_twice) + MF_W'(1);
    assign t_2  = MF_W'(i_j_twice) + MF_W'(2);

    always_comb begin
        term_a = '0;
        term_b = '0;
        m_1    = t_0;
        m_2    = t_2;
        dsh    = 2'd0;
        case (mode)
            MODE_P: begin
                m_1 = t_1;
                m_2 = t_2;
                dsh = 2'd1;
                case (dlam)
                    DL_ZERO: begin
                        term_a = t_s + K2 + l2_s;
                        term_b = t_s + K2 - l2_s;
                    end
                    DL_PLUS: begin
                        term_a = t_s + K2 - l2_s;
                        term_b = t_s + K4 - l2_s;
                    end
                    default: begin
                        term_a = t_s + K2 + l2_s;
                        term_b = t_s + K4 + l2_s;
                    end
                endcase
            end
            MODE_Q: begin
                m_1 = t_0;
                m_2 = t_2;
                dsh = 2'd0;
                case (dlam)
                    DL_ZERO: begin
                        term_a = l2_s;
                        term_b = l2_s;
                    end
                    DL_PLUS: begin
                        term_a = t_s + l2_s;
                        term_b = t_s + K2 - l2_s;
                    end
                    default: begin
                        term_a = t_s - l2_s;
                        term_b = t_s + K2 + l2_s;
                    end
                endcase
            end
            default: begin
                m_1 = t_0;
                m_2 = t_1;
                dsh = 2'd1;
                case (dlam)
                    DL_ZERO: begin
                        term_a = t_s + l2_s;
                        term_b = t_s - l2_s;
                    end
                    DL_PLUS: begin
                        term_a = t_s + l2_s;
                        term_b = t_s - K2 + l2_s;
                    end
                    default: begin
                        term_a = t_s - l2_s;
                        term_b = t_s - K2 - l2_s;
                    end
                endcase
            end
        endcase
        // nonzero Delta-Lambda carries the extra one half
        if (dlam != DL_ZERO) begin
            dsh = dsh + 2'd1;
        end
        ok = !(mode == MODE_NONE || dlam == DL_BAD
               || (mode != MODE_P && i_j_twice == '0));
    end

    assign n_prod = term_a * term_b;
    assign n_mden = m_1 * m_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok   <= ok;
        r_prod <= n_prod;
        r_mden <= n_mden;
        r_dsh  <= dsh;
    end

    always_comb begin
        neg = r_prod[NUM_W-1];
        mag = neg ? NUM_W'(-r_prod) : NUM_W'(r_prod);
        div = DIV_W'(r_mden) << (32'(r_dsh) + DEN_SHIFT);
        n_data     = '0;
        n_data.den = DIV_W'(1);
        if (r_ok) begin
            n_data.neg = neg;
            n_data.den = div;
            n_data.sat = CMP_W'(mag) >= CMP_W'(div);
            // a saturated item carries no remainder through the row
            n_data.rem = n_data.sat ? '0 : DIV_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_data;

endmodule

/* sv/hlf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlf_cell: one restoring-division cell
// Doubles the partial remainder, subtracts the divisor when it fits and
// shifts the resulting quotient bit in; hands the item to the next cell.
// ----------------------------------------------------------------------------
module hlf_cell import hlf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_valid,
    output t_cell_data o_data
);

    logic [DIV_W:0] rem_x2;
    logic [DIV_W:0] diff;
    logic           fits;
    logic           r_valid;
    t_cell_data     r_data;
    t_cell_data     n_data;

    assign rem_x2 = {i_data.rem, 1'b0};
    assign diff   = rem_x2 - {1'b0, i_data.den};
    assign fits   = rem_x2 >= {1'b0, i_data.den};

    always_comb begin
        n_data     = i_data;
        n_data.rem = fits ? diff[DIV_W-1:0] : rem_x2[DIV_W-1:0];
        n_data.quo = {i_data.quo[QUO_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_data.rem < r_data.den)
        else $error("remainder not below divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_data.den != '0)
        else $error("zero divisor in cell row");

    a_sat_no_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_data.sat |-> r_data.rem == '0 && r_data.quo == '0)
        else $error("saturated item carries remainder or quotient");

endmodule

/* sv/honl_london_factor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// honl_london_factor: rotational line-strength factor, one item per cycle
// Usage:
//   Drive mode, j_twice, lambda_value and delta_lambda with start high; the
//   item is taken at any edge where start is high and busy is low. busy is
//   always low, so a new item may enter every cycle.
//   Each item yields one factor on o_factor, signed with FRACTION_BITS
//   fraction bits, marked by o_valid for exactly one cycle, in input order.
//   Pipeline: two setup stages, a row of QUO_BITS division cells (one cell
//   per quotient bit) and one output register.
//   Throughput: one item per clock; the divider row is fully pipelined.
//   The receiver cannot stall; results are lost if not taken that cycle.
//   force_unity sits at APB byte address 0; write it only while no item is
//   in flight. Synchronous reset clears all valid flags and force_unity.
// ----------------------------------------------------------------------------
module honl_london_factor import hlf_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic [J_TWICE_BITS-1:0]       i_j_twice,
    input  logic [2:0]                    i_lambda_value,
    input  logic signed [1:0]             i_delta_lambda,
    output logic                          o_valid,
    output logic signed [FACTOR_BITS-1:0] o_factor,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic       r_force_unity;
    logic [1:0] reg_idx;
    logic       cfg_wr;

    logic       c_valid [0:QUO_BITS];
    t_cell_data c_data  [0:QUO_BITS];

    logic                          r_valid;
    logic signed [FACTOR_BITS-1:0] r_factor;
    logic signed [FACTOR_BITS-1:0] n_factor;
    t_cell_data                    last;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    assign reg_idx = 2'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_unity <= 1'b0;
        end else if (cfg_wr && reg_idx == REG_FORCE_UNITY) begin
            r_force_unity <= pwdata[0];
        end
    end

    assign prdata = (reg_idx == REG_FORCE_UNITY) ? {31'd0, r_force_unity} : 32'd0;

    hlf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start && !busy),
        .i_mode         (i_mode),
        .i_j_twice      (i_j_twice),
        .i_lambda_value (i_lambda_value),
        .i_delta_lambda (i_delta_lambda),
        .o_valid        (c_valid[0]),
        .o_data         (c_data[0])
    );

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_cell
        hlf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    assign last = c_data[QUO_BITS];

    always_comb begin
        if (r_force_unity) begin
            n_factor = FACTOR_ONE;
        end else if (last.sat) begin
            n_factor = last.neg ? FACTOR_MIN : FACTOR_MAX;
        end else if (last.neg) begin
            n_factor = -signed'({1'b0, last.quo});
        end else begin
            n_factor = signed'({1'b0, last.quo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= c_valid[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_factor <= n_factor;
    end

    assign o_valid  = r_valid;
    assign o_factor = r_factor;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the line-strength factor pipeline
// Drives branch, 2J, Lambda and Delta-Lambda items through a clocked driver
// and checks every factor against an in-bench predictor. The bench covers
// directed corner lines, then random lines under both force_unity settings.
// Sender gaps of 18 %, 55 % and none are used, with drain pauses between
// phases.
// ----------------------------------------------------------------------------
module testbench;
    import hlf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    localparam logic [2:0] ADDR_FORCE_UNITY = 3'({REG_FORCE_UNITY, 2'b00});
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

    typedef logic signed [FACTOR_BITS-1:0] t_factor;

    typedef struct {
        t_mode                   mode;
        logic [J_TWICE_BITS-1:0] j_twice;
        logic [2:0]              lambda_value;
        t_dlam                   delta_lambda;
    } t_line_item;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_mode;
    logic [J_TWICE_BITS-1:0] i_j_twice;
    logic [2:0]              i_lambda_value;
    logic signed [1:0]       i_delta_lambda;
    logic                    o_valid;
    t_factor                 o_factor;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    t_line_item pending_lines[$];
    t_factor    expected_factors[$];
    t_line_item driven_line;
    t_factor    oldest_factor;
    logic       unity_model;
    int         sender_idle_pct = 0;
    int         mismatch_count  = 0;
    int         accepted_count  = 0;
    int         checked_count   = 0;
    int         cycle_count     = 0;

    honl_london_factor u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_j_twice      (i_j_twice),
        .i_lambda_value (i_lambda_value),
        .i_delta_lambda (i_delta_lambda),
        .o_valid        (o_valid),
        .o_factor       (o_factor),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Relative line strength in signed fixed point, truncated toward zero
    function automatic t_factor line_strength_factor(t_line_item line, logic unity);
        longint t;
        longint l2;
        longint a;
        longint b;
        longint den;
        longint num;
        longint mag;
        bit     neg;
        bit     good;
        t    = longint'(line.j_twice);
        l2   = 2 * longint'(line.lambda_value);
        a    = 0;
        b    = 0;
        den  = 1;
        good = (line.mode != MODE_NONE) && (line.delta_lambda != DL_BAD) &&
               !(line.mode != MODE_P && t == 0);
        if (unity) return t_factor'(longint'(1) << FRACTION_BITS);
        if (!good) return '0;
        case (line.mode)
            MODE_P: begin
                den = 2 * (t + 1) * (t + 2);
                case (line.delta_lambda)
                    DL_ZERO: begin a = t + 2 + l2; b = t + 2 - l2; end
                    DL_PLUS: begin a = t + 2 - l2; b = t + 4 - l2; end
                    default: begin a = t + 2 + l2; b = t + 4 + l2; end
                endcase
            end
            MODE_Q: begin
                den = t * (t + 2);
                case (line.delta_lambda)
                    DL_ZERO: begin a = l2;     b = l2;         end
                    DL_PLUS: begin a = t + l2; b = t + 2 - l2; end
                    default: begin a = t - l2; b = t + 2 + l2; end
                endcase
            end
            default: begin
                den = 2 * t * (t + 1);
                case (line.delta_lambda)
                    DL_ZERO: begin a = t + l2; b = t - l2;     end
                    DL_PLUS: begin a = t + l2; b = t - 2 + l2; end
                    default: begin a = t - l2; b = t - 2 - l2; end
                endcase
            end
        endcase
        if (line.delta_lambda != DL_ZERO) den = den * 2;
        num = a * b;
        neg = num < 0;
        mag = ((neg ? -num : num) << FRACTION_BITS) / den;
        if (neg) begin
            if (mag >= (longint'(1) << (FACTOR_BITS - 1))) return FACTOR_MIN;
            return t_factor'(-mag);
        end
        if (mag >= longint'(FACTOR_MAX)) return FACTOR_MAX;
        return t_factor'(mag);
    endfunction

    task automatic note_mismatch(string what, longint want, longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endtask

    // Driver: one item per accepted start, gaps at the current idle rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_factors.push_back(line_strength_factor(driven_line, unity_model));
                accepted_count++;
            end
            if (!start || !busy) begin
                if (pending_lines.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    driven_line = pending_lines.pop_front();
                    i_mode         <= driven_line.mode;
                    i_j_twice      <= driven_line.j_twice;
                    i_lambda_value <= driven_line.lambda_value;
                    i_delta_lambda <= driven_line.delta_lambda;
                    start          <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest expected factor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_factors.size() == 0) begin
                note_mismatch("factor with none expected", 0, o_factor);
            end else begin
                oldest_factor = expected_factors.pop_front();
                checked_count++;
                if (o_factor !== oldest_factor)
                    note_mismatch("factor", oldest_factor, o_factor);
            end
        end
    end

    // Track the register and check reads of it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            unity_model <= 1'b0;
        end else if (psel && penable && pready && paddr == ADDR_FORCE_UNITY) begin
            if (pwrite)
                unity_model <= pwdata[0];
            else if (prdata !== {31'b0, unity_model})
                note_mismatch("force_unity readback", unity_model, prdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d factors outstanding",
                     cycle_count, expected_factors.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_lines.size() != 0 || start || expected_factors.size() != 0);
    endtask

    // Junk in the upper data bits must not matter
    task automatic set_force_unity(logic value);
        wait_drained();
        apb_access(1'b1, ADDR_FORCE_UNITY, ($urandom() & ~32'h1) | 32'(value));
        apb_access(1'b0, ADDR_FORCE_UNITY, 32'h0);
        @(negedge i_clk);
    endtask

    task automatic add_line(t_mode mode, int j_twice, int lambda_value, t_dlam dl);
        t_line_item line;
        line.mode         = mode;
        line.j_twice      = J_TWICE_BITS'(j_twice);
        line.lambda_value = 3'(lambda_value);
        line.delta_lambda = dl;
        pending_lines.push_back(line);
    endtask

    // Mostly valid lines; small J often, to reach saturation and sign flips
    task automatic add_random_lines(int count);
        int    pick;
        t_mode mode;
        t_dlam dl;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            mode = (pick < 8) ? MODE_NONE : t_mode'(2'($urandom_range(2)));
            pick = $urandom_range(99);
            dl   = (pick < 8)  ? DL_BAD  :
                   (pick < 39) ? DL_ZERO :
                   (pick < 70) ? DL_PLUS : DL_MINUS;
            add_line(mode,
                     ($urandom_range(99) < 30) ? $urandom_range(8)
                                               : $urandom_range((1 << J_TWICE_BITS) - 1),
                     $urandom_range(7), dl);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = '0;
        i_j_twice      = '0;
        i_lambda_value = '0;
        i_delta_lambda = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Corners: every branch and Delta-Lambda, field extremes
        add_line(MODE_P,    0,   0, DL_ZERO);
        add_line(MODE_P,    255, 7, DL_ZERO);
        add_line(MODE_P,    0,   7, DL_PLUS);
        add_line(MODE_P,    255, 0, DL_MINUS);
        add_line(MODE_Q,    0,   3, DL_ZERO);
        add_line(MODE_Q,    1,   7, DL_ZERO);
        add_line(MODE_Q,    255, 7, DL_PLUS);
        add_line(MODE_Q,    2,   1, DL_MINUS);
        add_line(MODE_Q,    3,   1, DL_ZERO);
        add_line(MODE_R,    0,   5, DL_ZERO);
        add_line(MODE_R,    1,   7, DL_ZERO);
        add_line(MODE_R,    255, 0, DL_PLUS);
        add_line(MODE_R,    3,   7, DL_MINUS);
        add_line(MODE_R,    3,   1, DL_ZERO);
        add_line(MODE_R,    2,   1, DL_ZERO);
        add_line(MODE_NONE, 10,  2, DL_ZERO);
        add_line(MODE_NONE, 255, 7, DL_MINUS);
        add_line(MODE_P,    5,   3, DL_BAD);
        add_line(MODE_Q,    255, 7, DL_BAD);
        wait_drained();

        // A write to an unmapped address must leave force_unity clear
        apb_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFF);
        @(negedge i_clk);
        add_line(MODE_P, 7, 2, DL_PLUS);
        add_line(MODE_Q, 0, 0, DL_ZERO);

        set_force_unity(1'b1);
        add_line(MODE_NONE, 0,   0, DL_ZERO);
        add_line(MODE_Q,    0,   4, DL_BAD);
        add_line(MODE_R,    1,   7, DL_ZERO);
        add_line(MODE_P,    255, 7, DL_MINUS);

        set_force_unity(1'b0);
        sender_idle_pct = 18;
        add_random_lines(350);
        wait_drained();
        add_random_lines(350);

        set_force_unity(1'b1);
        sender_idle_pct = 55;
        add_random_lines(150);

        set_force_unity(1'b0);
        add_random_lines(450);

        wait_drained();
        sender_idle_pct = 0;
        add_random_lines(350);

        set_force_unity(1'b1);
        add_random_lines(100);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_factors.size() != 0)
            note_mismatch("factors never delivered", expected_factors.size(), 0);
        $display("covered %0d lines over all branches and Delta-Lambda codes, force_unity 0 and 1,",
                 accepted_count);
        $display("sender gaps of 0, 18 and 55 percent; %0d factors checked, %0d mismatches",
                 checked_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/hlf_pkg.sv
sv/hlf_front.sv
sv/hlf_cell.sv
sv/honl_london_factor.sv
tb/sv/testbench.sv
